[rtl/dve_pkg.sv]
// ----------------------------------------------------------------------------
// dve_pkg
// shared types and constants of the divisor enumerator: queue item kinds,
// controller states and queue status
// ----------------------------------------------------------------------------
package dve_pkg;

	// width of the divisor field on the ports
	localparam int FIELD_BITS = 13;

	// entries in the queue between the trial front and the emit back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	// quotient bits resolved per cycle by the trial divider
	localparam int DIV_STEPS = 4;

	// what one queue entry carries
	typedef enum logic [1:0] {
		KIND_SMALL = 2'd0,  // divisor at or below the square root, emit in order
		KIND_CO    = 2'd1,  // co-divisor, goes on the stack
		KIND_DONE  = 2'd2   // end of the trials for this number
	} item_kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_TEST,
		F_DIV,
		F_SMALL,
		F_CO,
		F_DONE
	} front_state_t;

	typedef enum logic {
		B_RUN,
		B_POP
	} back_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

[rtl/divisor_enumerator_core.sv]
// ----------------------------------------------------------------------------
// divisor_enumerator_core
// lists every divisor of a positive integer in ascending order, one per
// result, with the largest divisor flagged as last
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low; busy then stays high
// until the final result of that number has been issued, so the block works
// on one number at a time. Results come out one per strobe and cannot be held
// off: result_valid is high for exactly one cycle per divisor, and the caller
// must take each one as it appears. Divisors appear in ascending order and
// last marks the final one (normally n itself); an input of zero yields no
// result at all, and bits of n_value above VALUE_BITS are ignored. Timing is
// set by the trial divider in the front: each trial value i is tested with
// i*i <= n and then divided into n, and each divisor found adds one or two
// queue writes. With 13-bit n there are at most 90 trials. The co-divisors
// then leave the stack one per cycle.
// ----------------------------------------------------------------------------
module divisor_enumerator_core #(
	parameter int VALUE_BITS  = 13,
	parameter int STACK_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [12:0] n_value,
	output logic        result_valid,
	output logic [12:0] divisor,
	output logic        last
);

	localparam int FB = dve_pkg::FIELD_BITS;
	localparam int QW = VALUE_BITS + 2;

	logic                   busy_q;
	logic                   start_accept;

	// front to queue
	logic                   q_push;
	logic [QW-1:0]          q_push_data;
	// queue to back
	logic                   q_pop;
	logic [QW-1:0]          q_pop_data;
	dve_pkg::queue_status_t q_status;

	logic                   res_valid;
	logic [VALUE_BITS-1:0]  res_value;
	logic                   res_last;
	logic                   item_done;

	// a transaction is taken only while no earlier number is still in flight
	assign start_accept = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start_accept) begin
			busy_q <= 1'b1;
		end else if (item_done) begin
			// final result goes to the output register at this edge
			busy_q <= 1'b0;
		end
	end

	// trial division and divisor classification
	dve_front #(
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_accept (start_accept),
		.n_in         (n_value[VALUE_BITS-1:0]),
		.q_status     (q_status),
		.push         (q_push),
		.push_data    (q_push_data)
	);

	// short queue so that the front keeps dividing while the back is busy
	dve_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.pop_data  (q_pop_data),
		.status    (q_status)
	);

	// ordering, co-divisor stack and output register
	dve_back #(
		.VALUE_BITS  (VALUE_BITS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_data    (q_pop_data),
		.q_status  (q_status),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_value (res_value),
		.res_last  (res_last),
		.item_done (item_done)
	);

	assign busy         = busy_q;
	assign result_valid = res_valid;
	assign divisor      = FB'(res_value);
	assign last         = res_last;

endmodule

[rtl/dve_queue.sv]
// ----------------------------------------------------------------------------
// dve_queue
// small first-in first-out queue that decouples the trial front from the
// emit back
// ----------------------------------------------------------------------------
module dve_queue #(
	parameter int WIDTH = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      pop_data,
	output dve_pkg::queue_status_t status
);

	localparam int AW  = dve_pkg::QUEUE_AW;
	localparam int CNW = AW + 1;

	logic [WIDTH-1:0] entry_q [dve_pkg::QUEUE_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   fill_q;
	logic             do_push;
	logic             do_pop;

	assign status.full  = (fill_q == CNW'(dve_pkg::QUEUE_DEPTH));
	assign status.empty = (fill_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[rtl/dve_front.sv]
// ----------------------------------------------------------------------------
// dve_front
// trial division front: walks trial values while their square stays within
// n, divides n by each one a few quotient bits a cycle and queues every
// divisor found together with its co-divisor
// ----------------------------------------------------------------------------
module dve_front #(
	parameter int VALUE_BITS = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start_accept,
	input  logic [VALUE_BITS-1:0]   n_in,
	input  dve_pkg::queue_status_t  q_status,
	output logic                    push,
	output logic [VALUE_BITS+1:0]   push_data
);

	localparam int IW     = (VALUE_BITS + 1) / 2 + 1;
	localparam int SQW    = 2 * IW;
	localparam int STEPS  = dve_pkg::DIV_STEPS;
	localparam int PADW   = ((VALUE_BITS + STEPS - 1) / STEPS) * STEPS;
	localparam int CHUNKS = PADW / STEPS;
	localparam int CW     = $clog2(CHUNKS + 1);

	dve_pkg::front_state_t state_q, state_nxt;

	logic [VALUE_BITS-1:0] n_q;
	logic [IW-1:0]         i_q;
	logic [SQW-1:0]        sq_q;
	logic [PADW-1:0]       dvd_q;
	logic [PADW-1:0]       quo_q;
	logic [IW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;

	logic [IW:0]           r_c;
	logic [PADW-1:0]       d_c;
	logic [PADW-1:0]       q_c;
	logic                  last_chunk;
	logic                  over_limit;
	logic                  rem_zero;
	logic                  co_differs;

	// a few restoring division steps per cycle
	always_comb begin
		r_c = {1'b0, rem_q};
		d_c = dvd_q;
		q_c = quo_q;
		for (int s = 0; s < STEPS; s++) begin
			r_c = {r_c[IW-1:0], d_c[PADW-1]};
			d_c = {d_c[PADW-2:0], 1'b0};
			q_c = {q_c[PADW-2:0], 1'b0};
			if (r_c >= {1'b0, i_q}) begin
				r_c    = r_c - {1'b0, i_q};
				q_c[0] = 1'b1;
			end
		end
	end

	assign last_chunk = (cnt_q == CW'(CHUNKS - 1));
	assign over_limit = (sq_q > SQW'(n_q));
	assign rem_zero   = (r_c[IW-1:0] == '0);
	assign co_differs = (quo_q != PADW'(i_q));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dve_pkg::F_IDLE: begin
				if (start_accept) state_nxt = dve_pkg::F_TEST;
			end
			dve_pkg::F_TEST: begin
				state_nxt = over_limit ? dve_pkg::F_DONE : dve_pkg::F_DIV;
			end
			dve_pkg::F_DIV: begin
				if (last_chunk) state_nxt = rem_zero ? dve_pkg::F_SMALL : dve_pkg::F_TEST;
			end
			dve_pkg::F_SMALL: begin
				if (!q_status.full) state_nxt = co_differs ? dve_pkg::F_CO : dve_pkg::F_TEST;
			end
			dve_pkg::F_CO: begin
				if (!q_status.full) state_nxt = dve_pkg::F_TEST;
			end
			dve_pkg::F_DONE: begin
				if (!q_status.full) state_nxt = dve_pkg::F_IDLE;
			end
			default: state_nxt = dve_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		push      = 1'b0;
		push_data = {dve_pkg::KIND_DONE, {VALUE_BITS{1'b0}}};
		case (state_q)
			dve_pkg::F_SMALL: begin
				push      = 1'b1;
				push_data = {dve_pkg::KIND_SMALL, VALUE_BITS'(i_q)};
			end
			dve_pkg::F_CO: begin
				push      = 1'b1;
				push_data = {dve_pkg::KIND_CO, quo_q[VALUE_BITS-1:0]};
			end
			dve_pkg::F_DONE: begin
				push      = 1'b1;
				push_data = {dve_pkg::KIND_DONE, {VALUE_BITS{1'b0}}};
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dve_pkg::F_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == dve_pkg::F_TEST) begin
			cnt_q <= '0;
		end else if (state_q == dve_pkg::F_DIV) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// trial value and its square advance together: (i+1)^2 = i^2 + 2i + 1
	always_ff @(posedge clk) begin
		case (state_q)
			dve_pkg::F_IDLE: begin
				if (start_accept) begin
					n_q  <= n_in;
					i_q  <= IW'(1);
					sq_q <= SQW'(1);
				end
			end
			dve_pkg::F_TEST: begin
				dvd_q <= PADW'(n_q);
				quo_q <= '0;
				rem_q <= '0;
			end
			dve_pkg::F_DIV: begin
				dvd_q <= d_c;
				quo_q <= q_c;
				rem_q <= r_c[IW-1:0];
				if (last_chunk && !rem_zero) begin
					i_q  <= i_q + 1'b1;
					sq_q <= sq_q + SQW'({i_q, 1'b1});
				end
			end
			dve_pkg::F_SMALL: begin
				if (!q_status.full && !co_differs) begin
					i_q  <= i_q + 1'b1;
					sq_q <= sq_q + SQW'({i_q, 1'b1});
				end
			end
			dve_pkg::F_CO: begin
				if (!q_status.full) begin
					i_q  <= i_q + 1'b1;
					sq_q <= sq_q + SQW'({i_q, 1'b1});
				end
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

endmodule

[rtl/dve_back.sv]
// ----------------------------------------------------------------------------
// dve_back
// emit back: sends the small divisors in order, stacks the co-divisors and
// pops them after the trials, marking the final result of each number
// ----------------------------------------------------------------------------
module dve_back #(
	parameter int VALUE_BITS  = 13,
	parameter int STACK_DEPTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [VALUE_BITS+1:0]   q_data,
	input  dve_pkg::queue_status_t  q_status,
	output logic                    pop,
	output logic                    res_valid,
	output logic [VALUE_BITS-1:0]   res_value,
	output logic                    res_last,
	output logic                    item_done
);

	localparam int AW  = $clog2(STACK_DEPTH);
	localparam int CNW = $clog2(STACK_DEPTH + 1);

	dve_pkg::back_state_t state_q, state_nxt;
	dve_pkg::item_kind_t  kind;

	logic [VALUE_BITS-1:0] stack_mem [STACK_DEPTH];
	logic [CNW-1:0]        count_q;
	logic [CNW-1:0]        count_dec;
	logic [VALUE_BITS-1:0] rdata_q;
	logic [VALUE_BITS-1:0] hold_q;
	logic                  hold_valid_q;
	logic [VALUE_BITS-1:0] value;

	logic                  emit;
	logic [VALUE_BITS-1:0] emit_val;
	logic                  emit_last;
	logic                  stack_push;
	logic                  stack_read;
	logic                  hold_load;
	logic                  hold_clear;
	logic                  stack_empty;

	logic                  res_valid_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic                  res_last_q;

	assign kind        = dve_pkg::item_kind_t'(q_data[VALUE_BITS+1:VALUE_BITS]);
	assign value       = q_data[VALUE_BITS-1:0];
	assign count_dec   = count_q - 1'b1;
	assign stack_empty = (count_q == '0);
	assign pop         = (state_q == dve_pkg::B_RUN) && !q_status.empty;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dve_pkg::B_RUN: begin
				if (pop && kind == dve_pkg::KIND_DONE && !stack_empty) begin
					state_nxt = dve_pkg::B_POP;
				end
			end
			dve_pkg::B_POP: begin
				if (stack_empty) state_nxt = dve_pkg::B_RUN;
			end
			default: state_nxt = dve_pkg::B_RUN;
		endcase
	end

	always_comb begin
		emit       = 1'b0;
		emit_val   = hold_q;
		emit_last  = 1'b0;
		stack_push = 1'b0;
		stack_read = 1'b0;
		hold_load  = 1'b0;
		hold_clear = 1'b0;
		item_done  = 1'b0;
		case (state_q)
			dve_pkg::B_RUN: begin
				if (pop) begin
					case (kind)
						dve_pkg::KIND_SMALL: begin
							emit      = hold_valid_q;
							hold_load = 1'b1;
						end
						dve_pkg::KIND_CO: begin
							stack_push = (count_q < CNW'(STACK_DEPTH));
						end
						dve_pkg::KIND_DONE: begin
							emit       = hold_valid_q;
							emit_last  = stack_empty;
							hold_clear = 1'b1;
							item_done  = stack_empty;
							stack_read = !stack_empty;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			dve_pkg::B_POP: begin
				emit       = 1'b1;
				emit_val   = rdata_q;
				emit_last  = stack_empty;
				stack_read = !stack_empty;
				item_done  = stack_empty;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dve_pkg::B_RUN;
			count_q      <= '0;
			hold_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			res_valid_q <= emit;
			if (stack_push) begin
				count_q <= count_q + 1'b1;
			end else if (stack_read) begin
				count_q <= count_dec;
			end
			if (hold_load) begin
				hold_valid_q <= 1'b1;
			end else if (hold_clear) begin
				hold_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stack_push) begin
			stack_mem[count_q[AW-1:0]] <= value;
		end
		if (stack_read) begin
			rdata_q <= stack_mem[count_dec[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (hold_load) begin
			hold_q <= value;
		end
		if (emit) begin
			res_value_q <= emit_val;
			res_last_q  <= emit_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_value = res_value_q;
	assign res_last  = res_last_q;

endmodule

[rtl/dve_checker.sv]
// ----------------------------------------------------------------------------
// dve_checker
// port-level checks on the divisor enumerator, bound to the top level
// ----------------------------------------------------------------------------
module dve_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        result_valid,
	input  logic [12:0] divisor,
	input  logic        last
);

	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accepted transaction");

	// results only belong to a number in flight
	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !$past(busy) |-> !result_valid)
		else $error("result while idle");

	// the final result is never directly followed by another
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result straight after last");

	// a divisor is never zero
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> divisor != 13'd0)
		else $error("zero divisor issued");

endmodule

bind divisor_enumerator_core dve_checker u_dve_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.divisor      (divisor),
	.last         (last)
);
